@@ sv/double_ended_queue_macros.svh @@
// ----------------------------------------------------------------------------
// double_ended_queue_macros.svh
// Assertion shorthands used by the deque RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Property that must hold at every edge outside reset.
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent this cycle implies consequent in the next cycle.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEQ_DEPTH      = 1024;
   localparam int DEQ_DATA_WIDTH = 32;
   localparam int DEQ_OCC_WIDTH  = 11;
   localparam int DEQ_KIND_WIDTH = 3;

   // operation codes; anything above KIND_INSPECT also only inspects
   localparam logic [DEQ_KIND_WIDTH-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [DEQ_KIND_WIDTH-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [DEQ_KIND_WIDTH-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [DEQ_KIND_WIDTH-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [DEQ_KIND_WIDTH-1:0] KIND_INSPECT    = 3'd4;

   typedef struct packed {
      logic [DEQ_KIND_WIDTH-1:0] kind;
      logic [DEQ_DATA_WIDTH-1:0] push_value;
   } deq_req_type;

   typedef struct packed {
      logic [DEQ_DATA_WIDTH-1:0] popped_value;
      logic                      underflow;
      logic                      overflow;
      logic [DEQ_OCC_WIDTH-1:0]  occupancy;
      logic                      is_empty;
      logic [DEQ_DATA_WIDTH-1:0] front_value;
      logic [DEQ_DATA_WIDTH-1:0] back_value;
   } deq_rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_FILL
   } deq_state_type;

endpackage

@@ sv/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = deq_pkg::DEQ_DATA_WIDTH,
   parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered when rd_en is high
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of data words held in a ring RAM.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one word per operation: push front, push back,
//   pop front, pop back or inspect. Each accepted word gives exactly one
//   rsp word with the popped value, underflow and overflow flags, and the
//   occupancy, empty flag, front and back values after the operation.
//   Front and back words are kept in registers beside the RAM, so pushes,
//   inspects, failed pops and pops that empty the queue have their response
//   registered at the accept edge. A pop that leaves words behind must
//   fetch the new front or back entry through the registered RAM read
//   port; its response is built in the ST_FILL state, and no new request
//   is taken until that refill is done.
//   The response sits in an output register; a new request is taken while
//   the register is empty or being emptied in the same cycle. When rsp_ready
//   stays low, req_ready drops and the queue holds its state.
//   Reset (synchronous, active high) clears the pointers and the count; the
//   RAM is not cleared, since only entries that hold queued words are read.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  deq_pkg::deq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output deq_pkg::deq_rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = deq_pkg::DEQ_DATA_WIDTH;
   localparam int OCC_W  = deq_pkg::DEQ_OCC_WIDTH;
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(DEPTH);

   // ring index helpers, wrap at DEPTH
   function automatic logic [ADDR_W-1:0] idx_inc(input logic [ADDR_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + ADDR_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] idx_dec(input logic [ADDR_W-1:0] i);
      return (i == '0) ? LAST_IDX : i - ADDR_W'(1);
   endfunction

   deq_pkg::deq_state_type state_ff, state_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] front_ff, front_in;
   logic [DATA_W-1:0] back_ff, back_in;
   logic              side_ff, side_in;     // 1: refill front, 0: refill back
   logic [DATA_W-1:0] popped_ff, popped_in;
   logic              rsp_valid_ff, rsp_valid_in;
   deq_pkg::deq_rsp_type rsp_data_ff, rsp_data_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;

   logic              req_fire;
   logic              load;
   logic              is_full;
   logic              is_empty_now;
   logic [DATA_W-1:0] r_popped;
   logic              r_under;
   logic              r_over;
   logic [CNT_W-1:0]  r_count;
   logic [DATA_W-1:0] r_front;
   logic [DATA_W-1:0] r_back;

   // ring store
   deq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign is_full      = (count_ff == FULL_CNT);
   assign is_empty_now = (count_ff == '0);

   // next state, RAM access and response build
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      front_in  = front_ff;
      back_in   = back_ff;
      side_in   = side_ff;
      popped_in = popped_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_dec(head_ff);
      wr_data   = req_data.push_value;
      rd_en     = 1'b0;
      rd_addr   = idx_inc(head_ff);
      load      = 1'b0;
      req_ready = 1'b0;
      req_fire  = 1'b0;
      r_popped  = '0;
      r_under   = 1'b0;
      r_over    = 1'b0;
      r_count   = count_ff;
      r_front   = front_ff;
      r_back    = back_ff;

      unique case (state_ff)
         deq_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            req_fire  = req_ready && req_valid;
            if (req_fire) begin
               load = 1'b1;
               unique case (req_data.kind)
                  deq_pkg::KIND_PUSH_FRONT: begin
                     if (is_full) begin
                        r_over = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = idx_dec(head_ff);
                        head_in  = idx_dec(head_ff);
                        count_in = count_ff + CNT_W'(1);
                        front_in = req_data.push_value;
                        if (is_empty_now) begin
                           back_in = req_data.push_value;
                        end
                     end
                  end
                  deq_pkg::KIND_PUSH_BACK: begin
                     if (is_full) begin
                        r_over = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = tail_ff;
                        tail_in  = idx_inc(tail_ff);
                        count_in = count_ff + CNT_W'(1);
                        back_in  = req_data.push_value;
                        if (is_empty_now) begin
                           front_in = req_data.push_value;
                        end
                     end
                  end
                  deq_pkg::KIND_POP_FRONT: begin
                     if (is_empty_now) begin
                        r_under = 1'b1;
                     end else begin
                        r_popped  = front_ff;
                        popped_in = front_ff;
                        head_in   = idx_inc(head_ff);
                        count_in  = count_ff - CNT_W'(1);
                        if (count_ff != CNT_W'(1)) begin
                           // new front lies in the RAM
                           rd_en    = 1'b1;
                           rd_addr  = idx_inc(head_ff);
                           side_in  = 1'b1;
                           load     = 1'b0;
                           state_in = deq_pkg::ST_FILL;
                        end
                     end
                  end
                  deq_pkg::KIND_POP_BACK: begin
                     if (is_empty_now) begin
                        r_under = 1'b1;
                     end else begin
                        r_popped  = back_ff;
                        popped_in = back_ff;
                        tail_in   = idx_dec(tail_ff);
                        count_in  = count_ff - CNT_W'(1);
                        if (count_ff != CNT_W'(1)) begin
                           // new back sits just before the new tail
                           rd_en    = 1'b1;
                           rd_addr  = idx_dec(idx_dec(tail_ff));
                           side_in  = 1'b0;
                           load     = 1'b0;
                           state_in = deq_pkg::ST_FILL;
                        end
                     end
                  end
                  default: begin
                     // inspect only
                  end
               endcase
               r_count = count_in;
               r_front = front_in;
               r_back  = back_in;
            end
         end
         deq_pkg::ST_FILL: begin
            // read data arrives; no write can hit this cycle
            load     = 1'b1;
            r_popped = popped_ff;
            if (side_ff) begin
               front_in = rd_data;
            end else begin
               back_in = rd_data;
            end
            r_front  = front_in;
            r_back   = back_in;
            state_in = deq_pkg::ST_IDLE;
         end
         default: begin
            state_in = deq_pkg::ST_IDLE;
         end
      endcase

      rsp_data_in.popped_value = r_popped;
      rsp_data_in.underflow    = r_under;
      rsp_data_in.overflow     = r_over;
      rsp_data_in.occupancy    = OCC_W'(r_count);
      rsp_data_in.is_empty     = (r_count == '0);
      rsp_data_in.front_value  = (r_count == '0) ? '0 : r_front;
      rsp_data_in.back_value   = (r_count == '0) ? '0 : r_back;

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      front_ff  <= front_in;
      back_ff   <= back_in;
      side_ff   <= side_in;
      popped_ff <= popped_in;
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "double_ended_queue_macros.svh"

   // count never passes the ring size
   `DEQ_ASSERT_ALWAYS(a_count_bound, count_ff <= FULL_CNT, "count above depth")
   // a refill ends in the next cycle, back in ST_IDLE
   `DEQ_ASSERT_NEXT(a_fill_short, state_ff == deq_pkg::ST_FILL, state_ff == deq_pkg::ST_IDLE, "refill did not finish")
   // refill only with words left and the response slot free
   `DEQ_ASSERT_ALWAYS(a_fill_slot, (state_ff != deq_pkg::ST_FILL) || ((count_ff != '0) && !rsp_valid_ff), "refill with empty queue or busy response")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded double-ended queue.
// ----------------------------------------------------------------------------
// A short table of directed operations comes first. It covers the empty
// deque, the widest and narrowest data, every operation and the spare kind
// codes. A random mix of growing, shrinking and mixed runs follows. The last
// phase drains the deque back to back and pops it while empty. Every
// response word is compared field by field with the table's response or
// with a behavioral copy of the deque. The sender works in bursts and the
// receiver stalls on its own pattern, with one long hold-off in the middle.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 600;
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AFTER   = 350;
   localparam int SETTLE_LIMIT = 5000;
   localparam int TAIL_CYCLES  = 8;
   localparam int PRINT_LIMIT  = 50;

   // kind codes above KIND_INSPECT decode as inspect
   localparam logic [deq_pkg::DEQ_KIND_WIDTH-1:0] KIND_SPARE_LO  = 3'd5;
   localparam logic [deq_pkg::DEQ_KIND_WIDTH-1:0] KIND_SPARE_MID = 3'd6;
   localparam logic [deq_pkg::DEQ_KIND_WIDTH-1:0] KIND_SPARE_HI  = 3'd7;

   typedef logic [deq_pkg::DEQ_DATA_WIDTH-1:0] data_word_type;
   typedef logic [deq_pkg::DEQ_KIND_WIDTH-1:0] kind_type;

   localparam data_word_type ALL_ONES = '1;

   typedef struct packed {
      kind_type             kind;
      data_word_type        value;
      logic                 typed;
      deq_pkg::deq_rsp_type want;
   } directed_row_type;

   // response shapes that can be read off directly
   localparam deq_pkg::deq_rsp_type RSP_ANY   = '0;
   localparam deq_pkg::deq_rsp_type RSP_EMPTY =
      {32'h0, 1'b0, 1'b0, 11'd0, 1'b1, 32'h0, 32'h0};
   localparam deq_pkg::deq_rsp_type RSP_UNDER =
      {32'h0, 1'b1, 1'b0, 11'd0, 1'b1, 32'h0, 32'h0};

   // directed operations; typed rows carry their response, the rest use the model
   localparam int DIRECTED_ROWS = 24;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      {deq_pkg::KIND_POP_FRONT,  32'h0,        1'b1, RSP_UNDER},
      {deq_pkg::KIND_POP_BACK,   ALL_ONES,     1'b1, RSP_UNDER},
      {deq_pkg::KIND_INSPECT,    32'h0,        1'b1, RSP_EMPTY},
      {KIND_SPARE_HI,            ALL_ONES,     1'b1, RSP_EMPTY},
      {deq_pkg::KIND_PUSH_BACK,  ALL_ONES,     1'b1,
         {32'h0, 1'b0, 1'b0, 11'd1, 1'b0, ALL_ONES, ALL_ONES}},
      {deq_pkg::KIND_POP_FRONT,  32'h0,        1'b1,
         {ALL_ONES, 1'b0, 1'b0, 11'd0, 1'b1, 32'h0, 32'h0}},
      {deq_pkg::KIND_PUSH_FRONT, 32'h0,        1'b1,
         {32'h0, 1'b0, 1'b0, 11'd1, 1'b0, 32'h0, 32'h0}},
      {deq_pkg::KIND_POP_BACK,   ALL_ONES,     1'b1, RSP_EMPTY},
      {deq_pkg::KIND_PUSH_FRONT, 32'hA5A5A5A5, 1'b0, RSP_ANY},
      {deq_pkg::KIND_PUSH_BACK,  32'h5A5A5A5A, 1'b0, RSP_ANY},
      {deq_pkg::KIND_PUSH_FRONT, 32'h00000001, 1'b0, RSP_ANY},
      {deq_pkg::KIND_PUSH_BACK,  32'h80000000, 1'b0, RSP_ANY},
      {KIND_SPARE_LO,            32'hDEADBEEF, 1'b0, RSP_ANY},
      {KIND_SPARE_MID,           ALL_ONES,     1'b0, RSP_ANY},
      {deq_pkg::KIND_POP_FRONT,  ALL_ONES,     1'b0, RSP_ANY},
      {deq_pkg::KIND_POP_BACK,   32'h0,        1'b0, RSP_ANY},
      {deq_pkg::KIND_POP_FRONT,  32'h0,        1'b0, RSP_ANY},
      {deq_pkg::KIND_INSPECT,    ALL_ONES,     1'b0, RSP_ANY},
      {deq_pkg::KIND_POP_BACK,   32'h0,        1'b0, RSP_ANY},
      {deq_pkg::KIND_POP_BACK,   32'h0,        1'b1, RSP_UNDER},
      {deq_pkg::KIND_PUSH_BACK,  32'h12345678, 1'b0, RSP_ANY},
      {deq_pkg::KIND_PUSH_BACK,  32'h9ABCDEF0, 1'b0, RSP_ANY},
      {deq_pkg::KIND_POP_FRONT,  32'h0,        1'b0, RSP_ANY},
      {deq_pkg::KIND_POP_FRONT,  32'h0,        1'b0, RSP_ANY}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   deq_pkg::deq_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   deq_pkg::deq_rsp_type rsp_data;

   // behavioral copy of the deque
   data_word_type ring_words [deq_pkg::DEQ_DEPTH];
   int unsigned   front_slot;
   int unsigned   free_slot;
   int unsigned   word_count;

   deq_pkg::deq_rsp_type pending_rsp [$];
   int unsigned   words_sent;
   int unsigned   words_checked;
   int unsigned   mismatches;
   int unsigned   overflow_seen;
   int unsigned   underflow_seen;
   int unsigned   peak_occupancy;
   int unsigned   cycle_count;
   int unsigned   burst_left;
   logic          gaps_on;

   double_ended_queue i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due", cycle_count,
                  pending_rsp.size());
         $display("FAIL double_ended_queue");
         $finish;
      end
   end

   function automatic int unsigned slot_prev(input int unsigned slot);
      return (slot == 0) ? deq_pkg::DEQ_DEPTH - 1 : slot - 1;
   endfunction

   function automatic int unsigned slot_next(input int unsigned slot);
      return (slot + 1 >= deq_pkg::DEQ_DEPTH) ? 0 : slot + 1;
   endfunction

   // apply one operation to the copy and return the response it gives
   function automatic deq_pkg::deq_rsp_type deque_step(input kind_type kind,
                                                       input data_word_type value);
      deq_pkg::deq_rsp_type rsp;
      rsp = '0;
      case (kind)
         deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
            if (word_count >= deq_pkg::DEQ_DEPTH) begin
               rsp.overflow = 1'b1;
            end else if (kind == deq_pkg::KIND_PUSH_FRONT) begin
               front_slot = slot_prev(front_slot);
               ring_words[front_slot] = value;
               word_count++;
            end else begin
               ring_words[free_slot] = value;
               free_slot = slot_next(free_slot);
               word_count++;
            end
         end
         deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
            if (word_count == 0) begin
               rsp.underflow = 1'b1;
            end else if (kind == deq_pkg::KIND_POP_FRONT) begin
               rsp.popped_value = ring_words[front_slot];
               front_slot = slot_next(front_slot);
               word_count--;
            end else begin
               free_slot = slot_prev(free_slot);
               rsp.popped_value = ring_words[free_slot];
               word_count--;
            end
         end
         default: begin
         end
      endcase
      rsp.occupancy = deq_pkg::DEQ_OCC_WIDTH'(word_count);
      rsp.is_empty  = (word_count == 0);
      if (word_count != 0) begin
         rsp.front_value = ring_words[front_slot];
         rsp.back_value  = ring_words[slot_prev(free_slot)];
      end
      return rsp;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
         $display("mismatch on response word %0d: %s got %0h want %0h",
                  words_checked, what, got, want);
      end
   endtask

   // offer one word, with a random gap at the end of each burst while gaps are on
   task automatic offer_word(input kind_type kind, input data_word_type value,
                             input logic typed, input deq_pkg::deq_rsp_type want);
      deq_pkg::deq_rsp_type predicted;
      int unsigned gap;
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      if (burst_left != 0) burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{kind: kind, push_value: value};
      do @(posedge clock); while (!req_ready);
      predicted = deque_step(kind, value);
      // append at the tail of the due list
      pending_rsp.insert(pending_rsp.size(), typed ? want : predicted);
      words_sent++;
   endtask

   // sender pause until every response is back
   task automatic wait_all_back();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic data_word_type pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ALL_ONES;
         default: return $urandom;
      endcase
   endfunction

   function automatic kind_type pick_push();
      return $urandom_range(0, 1) ? deq_pkg::KIND_PUSH_BACK : deq_pkg::KIND_PUSH_FRONT;
   endfunction

   function automatic kind_type pick_pop();
      return $urandom_range(0, 1) ? deq_pkg::KIND_POP_BACK : deq_pkg::KIND_POP_FRONT;
   endfunction

   // response check
   always @(posedge clock) begin : rsp_check
      deq_pkg::deq_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with none due, popped", rsp_data.popped_value, 0);
         end else begin
            // oldest due response
            want = pending_rsp[0];
            pending_rsp.delete(0);
            if (rsp_data.popped_value !== want.popped_value)
               report_mismatch("popped_value", rsp_data.popped_value, want.popped_value);
            if (rsp_data.underflow !== want.underflow)
               report_mismatch("underflow", rsp_data.underflow, want.underflow);
            if (rsp_data.overflow !== want.overflow)
               report_mismatch("overflow", rsp_data.overflow, want.overflow);
            if (rsp_data.occupancy !== want.occupancy)
               report_mismatch("occupancy", rsp_data.occupancy, want.occupancy);
            if (rsp_data.is_empty !== want.is_empty)
               report_mismatch("is_empty", rsp_data.is_empty, want.is_empty);
            if (rsp_data.front_value !== want.front_value)
               report_mismatch("front_value", rsp_data.front_value, want.front_value);
            if (rsp_data.back_value !== want.back_value)
               report_mismatch("back_value", rsp_data.back_value, want.back_value);
            if (want.overflow) overflow_seen++;
            if (want.underflow) underflow_seen++;
            if (want.occupancy > peak_occupancy) peak_occupancy = want.occupancy;
         end
         words_checked++;
      end
   end

   // receiver: stall pattern that changes mode at random, one long hold
   initial begin : rsp_stall
      int unsigned hold_count;
      int unsigned rx_tick;
      int unsigned rx_mode;
      logic        hold_done;
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      rx_tick   = 0;
      rx_mode   = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && words_checked >= HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            for (hold_count = 0; hold_count < LONG_HOLD; hold_count++) @(negedge clock);
            hold_done = 1'b1;
         end
         if (rx_tick % 48 == 0) rx_mode = $urandom_range(0, 3);
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= (rx_tick % 4 != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
         rx_tick++;
         @(negedge clock);
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int            row;
      int unsigned   seg_mode;
      int unsigned   seg_len;
      int unsigned   pick;
      int unsigned   random_end;
      int unsigned   settle;
      kind_type      kind;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      front_slot     = 0;
      free_slot      = 0;
      word_count     = 0;
      words_sent     = 0;
      words_checked  = 0;
      mismatches     = 0;
      overflow_seen  = 0;
      underflow_seen = 0;
      peak_occupancy = 0;
      cycle_count    = 0;
      burst_left     = 0;
      gaps_on        = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         offer_word(DIRECTED[row].kind, DIRECTED[row].value, DIRECTED[row].typed,
                    DIRECTED[row].want);
      end
      wait_all_back();

      // random runs that grow, shrink or mix
      random_end = words_sent + RANDOM_WORDS;
      while (words_sent < random_end) begin
         seg_mode = $urandom_range(0, 2);
         seg_len  = $urandom_range(20, 60);
         repeat (seg_len) begin
            pick = $urandom_range(0, 9);
            if (seg_mode == 0 || pick >= 7) kind = kind_type'($urandom_range(0, 7));
            else if (seg_mode == 1) kind = pick_push();
            else kind = pick_pop();
            offer_word(kind, pick_word(), 1'b0, RSP_ANY);
         end
      end
      wait_all_back();

      // drain to empty back to back, then pop the empty deque
      gaps_on = 1'b0;
      while (word_count != 0) begin
         if ($urandom_range(0, 9) == 0) kind = kind_type'($urandom_range(0, 7));
         else kind = pick_pop();
         offer_word(kind, pick_word(), 1'b0, RSP_ANY);
      end
      gaps_on = 1'b1;
      offer_word(deq_pkg::KIND_POP_FRONT, pick_word(), 1'b0, RSP_ANY);
      offer_word(deq_pkg::KIND_POP_BACK, pick_word(), 1'b0, RSP_ANY);
      @(negedge clock);
      req_valid <= 1'b0;

      // let the last responses come back, then watch for strays
      settle = 0;
      while (pending_rsp.size() != 0 && settle < SETTLE_LIMIT) begin
         @(posedge clock);
         settle++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $display("%0d responses never arrived", pending_rsp.size());
         mismatches += pending_rsp.size();
      end

      $display("%0d words through the deque: directed cases, random runs, drain; peak %0d",
               words_checked, peak_occupancy);
      $display("%0d dropped pushes, %0d empty pops, %0d mismatches, %0d cycles",
               overflow_seen, underflow_seen, mismatches, cycle_count);
      if (mismatches == 0) begin
         $display("PASS double_ended_queue");
      end else begin
         $display("FAIL double_ended_queue");
      end
      $finish;
   end

endmodule
